@@ src/cancrc_pkg.sv @@
// Package: shared constants, types and state encoding for the CAN CRC-15 block.
`default_nettype none
package cancrc_pkg;

  localparam int MAX_DATA_BYTES = 8;

  localparam int ID_W    = 11;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int CRC_W   = 15;
  localparam int HDR_BITS = ID_W + LEN_W;
  localparam int FRAME_W = ID_W + LEN_W + DATA_W;
  localparam int MAX_BITS = HDR_BITS + 8 * MAX_DATA_BYTES;
  localparam int BIT_CNT_W = $clog2(MAX_BITS + 1);

  localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic cap;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ src/cancrc_dp.sv @@
// Datapath: frame shift register, CRC-15 LFSR, bit counter and result register.
`default_nettype none
module cancrc_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cancrc_pkg::cmd_t             cmd,
  output cancrc_pkg::sts_t                  sts,
  input  wire logic [cancrc_pkg::ID_W-1:0]   frame_id,
  input  wire logic [cancrc_pkg::LEN_W-1:0]  length_code,
  input  wire logic [cancrc_pkg::DATA_W-1:0] data_bytes,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cancrc_pkg::CRC_W-1:0]      crc_value
);
  import cancrc_pkg::*;

  logic [FRAME_W-1:0]   frame;
  logic [CRC_W-1:0]     crc;
  logic [CRC_W-1:0]     crc_next;
  logic [BIT_CNT_W-1:0] count;
  logic [BIT_CNT_W-1:0] load_count;
  logic [LEN_W-1:0]     used;
  logic                 fb;

  always_comb begin
    if (length_code > LEN_W'(MAX_DATA_BYTES)) begin
      used = LEN_W'(MAX_DATA_BYTES);
    end else begin
      used = length_code;
    end
    load_count = BIT_CNT_W'(HDR_BITS) + (BIT_CNT_W'(used) << 3);
    fb = frame[FRAME_W-1] ^ crc[CRC_W-1];
    crc_next = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame <= {frame_id, length_code, data_bytes};
      crc   <= '0;
    end else if (cmd.shift) begin
      frame <= {frame[FRAME_W-2:0], 1'b0};
      crc   <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= load_count;
    end else if (cmd.shift) begin
      count <= count - BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.cap) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      crc_value <= crc;
    end
  end

  assign sts.last     = (count == BIT_CNT_W'(1));
  assign sts.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> count == '0) else $error("load while bits remain");
  a_cap_done: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |-> count == '0 && sts.out_free) else $error("capture before done");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> count >= BIT_CNT_W'(HDR_BITS) && count <= BIT_CNT_W'(MAX_BITS))
    else $error("bad bit count");
  a_cap_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |=> out_valid) else $error("result lost");
  a_shift_live: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> count != '0) else $error("shift past end");
`endif

endmodule
`default_nettype wire

@@ src/cancrc_ctrl.sv @@
// Controller: sequences load, bit shifting and result capture.
`default_nettype none
module cancrc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cancrc_pkg::sts_t  sts,
  output cancrc_pkg::cmd_t       cmd
);
  import cancrc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts.last) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.shift = 1'b0;
    cmd.cap   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
      end
      ST_HOLD: begin
        cmd.cap = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/can_crc15_frame.sv @@
// Top level: CAN CRC-15 over identifier, length code and used data bytes.
// Sequence: load in ST_IDLE, then shift one bit per cycle in ST_SHIFT over the
// 15 header bits and 8 bits per used data byte, then capture in ST_HOLD once
// the result register is free. A new frame is taken only after the last one is
// captured; the result register lets it start while the last result waits.
// Reset: synchronous rst clears the controller, bit counter and out_valid.
`default_nettype none
module can_crc15_frame (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [cancrc_pkg::ID_W-1:0]   frame_id,
  input  wire logic [cancrc_pkg::LEN_W-1:0]  length_code,
  input  wire logic [cancrc_pkg::DATA_W-1:0] data_bytes,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cancrc_pkg::CRC_W-1:0]      crc_value
);
  import cancrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cancrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cancrc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .frame_id    (frame_id),
    .length_code (length_code),
    .data_bytes  (data_bytes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .crc_value   (crc_value)
  );

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for can_crc15_frame: random and directed frames checked against a CRC-15 predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cancrc_pkg::*;

  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_BEATS = 1300;
  localparam int DRAIN_CYCLES = 100;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [ID_W-1:0]     frame_id;
  logic [LEN_W-1:0]    length_code;
  logic [DATA_W-1:0]   data_bytes;
  logic                out_valid;
  logic                out_ready;
  logic [CRC_W-1:0]    crc_value;

  logic calm;
  logic hold_request;

  class crc_scoreboard;
    logic [CRC_W-1:0] expected_crcs[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [CRC_W-1:0] frame_crc15(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                           logic [DATA_W-1:0] data);
      logic [CRC_W-1:0]   crc;
      logic [FRAME_W-1:0] bits;
      logic               fb;
      int                 nbits;
      crc   = '0;
      bits  = {id, len, data};
      nbits = HDR_BITS + 8 * ((int'(len) > MAX_DATA_BYTES) ? MAX_DATA_BYTES : int'(len));
      for (int k = 0; k < nbits; k++) begin
        fb  = bits[FRAME_W-1-k] ^ crc[CRC_W-1];
        crc = {crc[CRC_W-2:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
      return crc;
    endfunction

    function void note_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                             logic [DATA_W-1:0] data);
      expected_crcs.push_back(frame_crc15(id, len, data));
    endfunction

    function void check_crc(logic [CRC_W-1:0] got);
      logic [CRC_W-1:0] want;
      if (expected_crcs.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected crc_value %h", got);
        end
        return;
      end
      want = expected_crcs.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("crc_value mismatch: expected %h, got %h", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_crcs.size();
    endfunction

    function void close();
      if (pending() != 0) begin
        errors += pending();
        $display("%0d crc results never arrived", pending());
      end
    endfunction
  endclass

  crc_scoreboard sb = new();

  can_crc15_frame dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_id    (frame_id),
    .length_code (length_code),
    .data_bytes  (data_bytes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .crc_value   (crc_value)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic idle_sender();
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
  endtask

  task automatic send_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                            logic [DATA_W-1:0] data);
    idle_sender();
    in_valid    <= 1'b1;
    frame_id    <= id;
    length_code <= len;
    data_bytes  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_frame(id, len, data);
  endtask

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_crc(crc_value);
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    frame_id     = '0;
    length_code  = '0;
    data_bytes   = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_frame('0, '0, '0);
    send_frame('1, '1, '1);
    send_frame('1, '0, '1);
    send_frame('0, 4'd8, '1);
    send_frame('1, 4'd8, '0);
    send_frame(11'h555, 4'hA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_frame(11'h2AA, 4'h5, 64'h5555_5555_5555_5555);
    for (int len = 0; len < 16; len++) begin
      send_frame(11'($urandom_range(2047)), LEN_W'(len), rand_data());
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= 300 && i < 500);
      if (i == 700) begin
        hold_request = 1'b1;
      end
      send_frame(11'($urandom_range(2047)), 4'($urandom_range(15)), rand_data());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
